[sv/rrqs_pkg.sv]
package rrqs_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_YIELD  = 3'd3,
    CMD_SET    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2
  } tstate_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_MOVE_RD,
    S_MOVE_WR,
    S_CUR_RD,
    S_CUR_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PICK_RD,
    S_PICK_WR,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [1:0]  st;
    logic [7:0]  prio;
    logic [7:0]  quanta;
    logic [63:0] ctx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [63:0] context_word;
    logic [1:0]  new_state;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_task;
    logic [7:0]  next_task_id;
    logic [63:0] next_context;
  } result_t;

endpackage

[sv/rrqs_if.sv]
interface rrqs_in_if;
  import rrqs_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrqs_out_if;
  import rrqs_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/rrqs_ram.sv]
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/round_robin_quantum_scheduler.sv]
// Commands are handled one at a time: the id search for remove and set-state reads one
// table entry per cycle, and the round-robin scan for tick/yield reads and checks each entry
// in separate states (S_SCAN_RD, S_SCAN_CHK) on the registered-read table. The next command
// is taken in S_IDLE after the result is registered, which waits in S_OUT only while the
// previous word is still held.
// Reset (rst_n, synchronous): empty table, cursor and current slot zero, no current task.
module round_robin_quantum_scheduler #(
  parameter int MAX_TASKS = 64
) (
  input logic       clk,
  input logic       rst_n,
  rrqs_in_if.sink   in_ch,
  rrqs_out_if.source out_ch
);
  import rrqs_pkg::*;

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  fsm_t           st_r, st_nxt;
  item_t          it_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  cur_r, cur_nxt;
  logic           curv_r, curv_nxt;
  logic [AW-1:0]  csr_r, csr_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  steps_r, steps_nxt;
  logic [AW-1:0]  fnd_r, fnd_nxt;
  result_t        res_r, res_nxt;
  result_t        out_r, out_nxt;
  logic           ovld_r, ovld_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  entry_t         wdata, rd;
  logic [ENTRY_W-1:0] rdata_raw;

  rrqs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_tbl (
    .clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rdata_raw)
  );
  assign rd = entry_t'(rdata_raw);

  logic [AW-1:0] cnt_last;
  logic [AW-1:0] csr_inc;
  assign cnt_last = AW'(cnt_r - CW'(1));
  assign csr_inc  = (CW'(csr_r) + CW'(1) >= cnt_r) ? '0 : AW'(csr_r + AW'(1));

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      cur_r  <= '0;
      curv_r <= 1'b0;
      csr_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      cur_r  <= cur_nxt;
      curv_r <= curv_nxt;
      csr_r  <= csr_nxt;
      ovld_r <= ovld_nxt;
    end
    idx_r   <= idx_nxt;
    steps_r <= steps_nxt;
    fnd_r   <= fnd_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    if (in_ch.valid && in_ch.ready) begin
      it_r <= in_ch.data;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:     if (in_ch.valid) st_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (it_r.command)
          CMD_ADD:              st_nxt = S_OUT;
          CMD_REMOVE, CMD_SET:  st_nxt = (cnt_r == '0) ? S_OUT : S_FIND;
          CMD_TICK, CMD_YIELD:  st_nxt = (curv_r && CW'(cur_r) < cnt_r) ? S_CUR_RD
                                       : ((cnt_r == '0) ? S_OUT : S_SCAN_RD);
          default:              st_nxt = S_OUT;
        endcase
      end
      S_FIND: begin
        if (idx_r != '0 && rd.id == it_r.task_id) begin
          st_nxt = (it_r.command == CMD_REMOVE) ? S_MOVE_RD : S_OUT;
        end else if (idx_r == cnt_r) begin
          st_nxt = S_OUT;
        end
      end
      S_MOVE_RD:  st_nxt = S_MOVE_WR;
      S_MOVE_WR:  st_nxt = S_OUT;
      S_CUR_RD:   st_nxt = S_CUR_WR;
      S_CUR_WR:   st_nxt = S_SCAN_RD;
      S_SCAN_RD:  st_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rd.st == TS_READY || rd.st == TS_RUNNING || steps_r == cnt_r) begin
          st_nxt = S_PICK_RD;
        end else begin
          st_nxt = S_SCAN_RD;
        end
      end
      S_PICK_RD:  st_nxt = S_PICK_WR;
      S_PICK_WR:  st_nxt = S_OUT;
      S_OUT:      if (!ovld_r || out_ch.ready) st_nxt = S_IDLE;
      default:    st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    curv_nxt  = curv_r;
    csr_nxt   = csr_r;
    idx_nxt   = idx_r;
    steps_nxt = steps_r;
    fnd_nxt   = fnd_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ovld_nxt  = ovld_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rd;
    raddr     = '0;
    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;
    case (st_r)
      S_IDLE: ;
      S_DISPATCH: begin
        res_nxt = '0;
        if (curv_r && CW'(cur_r) >= cnt_r) curv_nxt = 1'b0;
        idx_nxt   = '0;
        steps_nxt = '0;
        raddr     = '0;
        case (it_r.command)
          CMD_ADD: begin
            if (cnt_r < CW'(MAX_TASKS)) begin
              we          = 1'b1;
              waddr       = AW'(cnt_r);
              wdata.id    = it_r.task_id;
              wdata.st    = TS_READY;
              wdata.prio  = it_r.task_priority;
              wdata.quanta = it_r.task_priority;
              wdata.ctx   = it_r.context_word;
              cnt_nxt     = cnt_r + CW'(1);
            end else begin
              res_nxt.status = STAT_FULL;
            end
          end
          CMD_REMOVE, CMD_SET: begin
            if (cnt_r == '0) res_nxt.status = STAT_NOTFOUND;
            idx_nxt = CW'(1);
          end
          CMD_TICK, CMD_YIELD: begin
            raddr = cur_r;
            if (cnt_r == '0) res_nxt.next_context = it_r.context_word;
          end
          default: ;
        endcase
      end
      S_FIND: begin
        raddr = AW'(idx_r);
        if (idx_r != '0 && rd.id == it_r.task_id) begin
          fnd_nxt = AW'(idx_r - CW'(1));
          if (it_r.command == CMD_REMOVE) begin
            raddr = cnt_last;
          end else begin
            we       = 1'b1;
            waddr    = AW'(idx_r - CW'(1));
            wdata.st = (it_r.new_state == TS_READY || it_r.new_state == TS_RUNNING)
                       ? it_r.new_state : TS_BLOCKED;
          end
        end else if (idx_r == cnt_r) begin
          res_nxt.status = STAT_NOTFOUND;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_MOVE_RD: raddr = cnt_last;
      S_MOVE_WR: begin
        we    = 1'b1;
        waddr = fnd_r;
        wdata = rd;
        if (curv_r && cur_r == fnd_r) curv_nxt = 1'b0;
        else if (curv_r && cur_r == cnt_last) cur_nxt = fnd_r;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_nxt != '0 && CW'(csr_r) >= cnt_nxt) csr_nxt = AW'(cnt_nxt - CW'(1));
      end
      S_CUR_RD: raddr = cur_r;
      S_CUR_WR: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = rd;
        wdata.ctx = it_r.context_word;
        if (rd.st == TS_RUNNING) begin
          if (it_r.command == CMD_YIELD) begin
            wdata.st = TS_READY;
          end else begin
            if (rd.quanta > 8'd0) wdata.quanta = rd.quanta - 8'd1;
            if (wdata.quanta == 8'd0) begin
              wdata.st     = TS_READY;
              wdata.quanta = rd.prio;
            end
          end
        end
      end
      S_SCAN_RD: begin
        raddr     = csr_inc;
        csr_nxt   = csr_inc;
        steps_nxt = steps_r + CW'(1);
      end
      S_SCAN_CHK: begin
        if (rd.st == TS_READY || rd.st == TS_RUNNING) begin
          fnd_nxt = csr_r;
        end else if (steps_r == cnt_r) begin
          fnd_nxt = '0;
        end
        raddr = cur_r;
      end
      S_PICK_RD: begin
        raddr = fnd_r;
        if (curv_r && cur_r != fnd_r && rd.st == TS_RUNNING) begin
          we       = 1'b1;
          waddr    = cur_r;
          wdata    = rd;
          wdata.st = TS_READY;
        end
      end
      S_PICK_WR: begin
        we       = 1'b1;
        waddr    = fnd_r;
        wdata    = rd;
        wdata.st = TS_RUNNING;
        cur_nxt  = fnd_r;
        curv_nxt = 1'b1;
        res_nxt.next_task_id = rd.id;
        res_nxt.next_context = rd.ctx;
      end
      S_OUT: begin
        if (!ovld_r || out_ch.ready) begin
          out_nxt          = res_r;
          out_nxt.has_task = (cnt_r != '0);
          ovld_nxt         = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

[tb/tb_round_robin_quantum_scheduler.sv]
`timescale 1ns / 1ps

module tb_round_robin_quantum_scheduler;
  import rrqs_pkg::*;

  localparam int NTASK = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int errors = 0;

  always #5 clk = ~clk;

  rrqs_in_if  in_ch ();
  rrqs_out_if out_ch ();

  round_robin_quantum_scheduler #(.MAX_TASKS(NTASK)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  class sched_scoreboard;
    logic [7:0]  tid  [NTASK];
    tstate_t     tst  [NTASK];
    logic [7:0]  tpri [NTASK];
    logic [7:0]  tqnt [NTASK];
    logic [63:0] tctx [NTASK];
    int count, cur, run_slot;
    bit run_valid;
    result_t pending[$];

    function int lookup(logic [7:0] id);
      for (int i = 0; i < count; i++) if (tid[i] == id) return i;
      return count;
    endfunction

    function int scan();
      for (int i = 0; i < count; i++) begin
        cur = (cur + 1) % count;
        if (tst[cur] == TS_READY || tst[cur] == TS_RUNNING) return cur;
      end
      return 0;
    endfunction

    function void note_word(item_t it);
      result_t r;
      int i, last, p;
      r = '0;
      if (run_valid && run_slot >= count) run_valid = 0;
      case (it.command)
        CMD_ADD: begin
          if (count < NTASK) begin
            tid[count] = it.task_id; tst[count] = TS_READY;
            tpri[count] = it.task_priority; tqnt[count] = it.task_priority;
            tctx[count] = it.context_word; count++;
          end else r.status = STAT_FULL;
        end
        CMD_REMOVE: begin
          i = lookup(it.task_id);
          if (i >= count) r.status = STAT_NOTFOUND;
          else begin
            last = count - 1;
            if (run_valid && run_slot == i) run_valid = 0;
            else if (run_valid && run_slot == last) run_slot = i;
            tid[i] = tid[last]; tst[i] = tst[last]; tpri[i] = tpri[last];
            tqnt[i] = tqnt[last]; tctx[i] = tctx[last];
            count = last;
            if (cur >= count && count > 0) cur = count - 1;
          end
        end
        CMD_TICK, CMD_YIELD: begin
          if (run_valid) begin
            i = run_slot;
            tctx[i] = it.context_word;
            if (tst[i] == TS_RUNNING) begin
              if (it.command == CMD_YIELD) tst[i] = TS_READY;
              else begin
                if (tqnt[i] > 0) tqnt[i]--;
                if (tqnt[i] == 0) begin
                  tst[i] = TS_READY; tqnt[i] = tpri[i];
                end
              end
            end
          end
          if (count == 0) r.next_context = it.context_word;
          else begin
            p = scan();
            if (run_valid && run_slot != p && tst[run_slot] == TS_RUNNING)
              tst[run_slot] = TS_READY;
            tst[p] = TS_RUNNING; run_slot = p; run_valid = 1;
            r.next_task_id = tid[p]; r.next_context = tctx[p];
          end
        end
        CMD_SET: begin
          i = lookup(it.task_id);
          if (i >= count) r.status = STAT_NOTFOUND;
          else tst[i] = (it.new_state > TS_BLOCKED) ? TS_BLOCKED : tstate_t'(it.new_state);
        end
        default: ;
      endcase
      r.has_task = (count > 0);
      pending.push_back(r);
    endfunction

    task check_word(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        report("unexpected word", 64'(got.status), 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
      if (got.has_task !== w.has_task) report("has_task", 64'(got.has_task), 64'(w.has_task));
      if (got.next_task_id !== w.next_task_id)
        report("next_task_id", 64'(got.next_task_id), 64'(w.next_task_id));
      if (got.next_context !== w.next_context)
        report("next_context", got.next_context, w.next_context);
    endtask
  endclass

  sched_scoreboard sb = new();
  logic [7:0] used_ids[$];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(input item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(it);
    if (it.command == CMD_ADD) used_ids.push_back(it.task_id);
  endtask

  function automatic item_t make(cmd_t c, logic [7:0] id, logic [7:0] pr,
                                 logic [63:0] cx, logic [1:0] ns);
    item_t it;
    it.command = c; it.task_id = id; it.task_priority = pr;
    it.context_word = cx; it.new_state = ns;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 9) < 8)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return 8'($urandom());
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
  endtask

  // result side: random stalls
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
    end
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    item_t it;
    int r;
    logic [2:0] c;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-table cases, then edge-value adds and commands on the small table, including invalid command codes
    send(make(CMD_TICK, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0));
    send(make(CMD_YIELD, 8'h00, 8'h00, 64'h0, 2'd0));
    send(make(CMD_REMOVE, 8'hFF, 8'h00, 64'h0, 2'd0));
    send(make(CMD_SET, 8'h12, 8'h00, 64'h0, 2'd1));
    send(make(CMD_ADD, 8'h00, 8'h00, 64'h0, 2'd3));
    send(make(CMD_ADD, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0));
    send(make(CMD_ADD, 8'hFF, 8'h02, 64'h1234, 2'd0));
    send(make(CMD_TICK, 8'h00, 8'h00, 64'hA5A5, 2'd0));
    send(make(CMD_TICK, 8'h00, 8'h00, 64'h5A5A, 2'd0));
    send(make(CMD_TICK, 8'h00, 8'h00, 64'h1, 2'd0));
    send(make(CMD_YIELD, 8'h00, 8'h00, 64'h2, 2'd0));
    send(make(CMD_SET, 8'hFF, 8'h00, 64'h0, 2'd3));
    send(make(CMD_SET, 8'h00, 8'h00, 64'h0, 2'd2));
    send(make(CMD_TICK, 8'h00, 8'h00, 64'h3, 2'd0));
    send(make(CMD_SET, 8'hFF, 8'h00, 64'h0, 2'd0));
    send(make(CMD_REMOVE, 8'hFF, 8'h00, 64'h0, 2'd0));
    send(make(cmd_t'(3'd5), 8'h00, 8'h00, 64'h7, 2'd0));
    send(make(cmd_t'(3'd7), 8'hFF, 8'hFF, 64'h7, 2'd3));
    // fill to full, then overflow, then a tick
    while (sb.count < NTASK)
      send(make(CMD_ADD, 8'($urandom()), 8'($urandom_range(0, 4)), rand64(), 2'd0));
    send(make(CMD_ADD, 8'h77, 8'h01, 64'h9, 2'd0));
    send(make(CMD_TICK, 8'h00, 8'h00, rand64(), 2'd0));
    drain();

    for (int n = 0; n < 560; n++) begin
      if (n == 300) drain();
      r = $urandom_range(0, 99);
      if (sb.count < 3 && r < 50) r = 0;
      if (sb.count > 56 && r < 20) r = 20;
      if (r < 20) c = CMD_ADD;
      else if (r < 35) c = CMD_REMOVE;
      else if (r < 65) c = CMD_TICK;
      else if (r < 77) c = CMD_YIELD;
      else if (r < 97) c = CMD_SET;
      else c = 3'($urandom_range(5, 7));
      it = make(cmd_t'(c), pick_id(),
                ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)),
                rand64(), 2'($urandom()));
      if (c == CMD_SET && $urandom_range(0, 2) != 0) it.new_state = 2'(TS_READY);
      send(it);
    end

    drain();
    repeat (2 * NTASK + 20) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
